// ===== sv/sha256_message_digest_macros.svh =====
// assertion macros for the sha-256 message digest block
// used by files that carry concurrent checks; expects clk and rst_n in scope
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHA_ASSERT_IMP(lbl, ante, cons, msg)
`define SHA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/sha256_pkg.sv =====
// shared constants and functions for the sha-256 message digest block
// no dependencies
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_s0(input word_t x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_s1(input word_t x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_s0(input word_t x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_s1(input word_t x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== sv/sha256_message_digest.sv =====
// sha-256 message digest: one byte per input beat, eight digest words out
// a byte that fills a block starts compression: 64 rounds of the shared round
// unit, then one fold
// end beat: padding bytes go in one per cycle, pausing while each full block
// is compressed, then the eight digest words leave one per accepted output beat
// reset (asynchronous, active low) gives the initial hash value and empty block
`include "sha256_message_digest_macros.svh"
module sha256_message_digest
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_PAD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]   state_reg,   state_next;
    word_t        chain_reg [8];
    word_t        chain_next [8];
    word_t        work_reg [8];
    word_t        work_next [8];
    word_t        work_rnd [8];
    word_t        w_new;
    logic [511:0] blk_reg,     blk_next;
    logic [5:0]   pos_reg,     pos_next;
    logic [5:0]   round_reg,   round_next;
    logic [63:0]  bitlen_reg,  bitlen_next;
    logic [63:0]  lensh_reg,   lensh_next;
    logic         ending_reg,  ending_next;
    logic         sent80_reg,  sent80_next;
    logic         lenph_reg,   lenph_next;
    logic [2:0]   idx_reg,     idx_next;
    logic         do_byte;
    logic [7:0]   byte_val;

    // shared round unit
    sha256_round u_round (
        .work    (work_reg),
        .sched   (blk_reg),
        .k       (ROUND_K[round_reg]),
        .work_nx (work_rnd),
        .w_new   (w_new)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        chain_next  = chain_reg;
        work_next   = work_reg;
        blk_next    = blk_reg;
        pos_next    = pos_reg;
        round_next  = round_reg;
        bitlen_next = bitlen_reg;
        lensh_next  = lensh_reg;
        ending_next = ending_reg;
        sent80_next = sent80_reg;
        lenph_next  = lenph_reg;
        idx_next    = idx_reg;
        do_byte     = 1'b0;
        byte_val    = data_byte;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    do_byte = has_byte;
                    if (has_byte)
                        bitlen_next = bitlen_reg + 64'd8;
                    if (end_of_message)
                    begin
                        ending_next = 1'b1;
                        sent80_next = 1'b0;
                        lenph_next  = 1'b0;
                        lensh_next  = bitlen_reg + (has_byte ? 64'd8 : 64'd0);
                        bitlen_next = '0;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                do_byte = 1'b1;
                if (!sent80_reg)
                begin
                    byte_val    = PAD_MARK;
                    sent80_next = 1'b1;
                end
                else if (lenph_reg || (pos_reg == LEN_POS))
                begin
                    byte_val   = lensh_reg[63:56];
                    lensh_next = {lensh_reg[55:0], 8'd0};
                    lenph_next = 1'b1;
                end
                else
                    byte_val = 8'd0;
            end
            ST_COMP:
            begin
                work_next  = work_rnd;
                blk_next   = {blk_reg[479:0], w_new};
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                for (int j = 0; j < 8; j++)
                    chain_next[j] = chain_reg[j] + work_reg[j];
                idx_next = '0;
                if (!ending_reg)
                    state_next = ST_IDLE;
                else if (lenph_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        chain_next  = INIT_HASH;
                        ending_next = 1'b0;
                        lenph_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        // byte packing, shared by message and padding bytes
        if (do_byte)
        begin
            blk_next = {blk_reg[503:0], byte_val};
            pos_next = pos_reg + 6'd1;
            if (pos_reg == 6'd63)
            begin
                work_next  = chain_reg;
                round_next = '0;
                state_next = ST_COMP;
            end
        end
    end

    // control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            chain_reg  <= INIT_HASH;
            work_reg   <= '{default: '0};
            pos_reg    <= '0;
            round_reg  <= '0;
            bitlen_reg <= '0;
            ending_reg <= 1'b0;
            sent80_reg <= 1'b0;
            lenph_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            chain_reg  <= chain_next;
            work_reg   <= work_next;
            pos_reg    <= pos_next;
            round_reg  <= round_next;
            bitlen_reg <= bitlen_next;
            ending_reg <= ending_next;
            sent80_reg <= sent80_next;
            lenph_reg  <= lenph_next;
            idx_reg    <= idx_next;
        end
    end

    // block buffer and length shifter
    always_ff @(posedge clk)
    begin
        blk_reg   <= blk_next;
        lensh_reg <= lensh_next;
    end

    // checks
    `SHA_ASSERT_IMP(a_out_blocks_in, out_valid, in_stall, "input open during output")
    `SHA_ASSERT_IMP(a_round_idle, state_reg != ST_COMP, round_reg == 6'd0, "stray round count")
    `SHA_ASSERT_NXT(a_last_to_idle, out_valid && !out_stall && last_word, !in_stall, "no idle after digest")
    `SHA_ASSERT_IMP(a_out_only_ending, out_valid, ending_reg && lenph_reg, "output without padding")

endmodule

// ===== sv/sha256_round.sv =====
// one sha-256 round and one message schedule step
// depends on sha256_pkg
module sha256_round
    import sha256_pkg::*;
(
    input  word_t        work [8],
    input  logic [511:0] sched,
    input  word_t        k,
    output word_t        work_nx [8],
    output word_t        w_new
);

    word_t t1;
    word_t t2;
    word_t wt;

    // schedule window holds w[t] .. w[t+15], w[t] in the top word
    assign wt    = sched[511:480];
    assign w_new = small_s1(sched[63:32]) + sched[223:192]
                 + small_s0(sched[479:448]) + wt;

    // round function
    assign t1 = work[7] + big_s1(work[4])
              + ((work[4] & work[5]) ^ (~work[4] & work[6])) + k + wt;
    assign t2 = big_s0(work[0])
              + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));

    assign work_nx[0] = t1 + t2;
    assign work_nx[1] = work[0];
    assign work_nx[2] = work[1];
    assign work_nx[3] = work[2];
    assign work_nx[4] = work[3] + t1;
    assign work_nx[5] = work[4];
    assign work_nx[6] = work[5];
    assign work_nx[7] = work[6];

endmodule
